FILE: src/dgsp_pkg.sv
package dgsp_pkg;

   // Default sizes of the storage inside the core.
   localparam int DEF_MAX_VERTICES  = 16;
   localparam int DEF_WEIGHT_BITS   = 16;
   localparam int DEF_DISTANCE_BITS = 24;

   // Field widths of the two data channels.
   localparam int VERTEX_INDEX_W = 4;
   localparam int EDGE_WEIGHT_W  = 16;
   localparam int PATH_LENGTH_W  = 24;

   // Register file geometry and register indexes.
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 1;
   localparam int VERTEX_COUNT_W = 5;
   localparam logic [CSR_INDEX_W-1:0] REG_VERTEX_COUNT  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_VERTEX = 1'b1;
   localparam logic [VERTEX_COUNT_W-1:0] VERTEX_COUNT_RESET = 5'd16;
   localparam logic [VERTEX_INDEX_W-1:0] SOURCE_VERTEX_RESET = 4'd0;
   localparam int MIN_VERTICES = 2;

   // One weight of the adjacency matrix.
   typedef struct packed {
      logic [VERTEX_INDEX_W-1:0] from_vertex;
      logic [VERTEX_INDEX_W-1:0] to_vertex;
      logic [EDGE_WEIGHT_W-1:0]  edge_weight;
      logic                      last_weight;
   } req_word_type;

   // One per-vertex result.
   typedef struct packed {
      logic [VERTEX_INDEX_W-1:0] vertex_index;
      logic [PATH_LENGTH_W-1:0]  path_length;
      logic                      reachable;
      logic                      last_vertex;
   } rsp_word_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic init;
      logic pick_issue;
      logic settle;
      logic relax_issue;
      logic out_load;
   } dp_cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic have_known;
      logic rsp_taken;
   } dp_status_type;

endpackage

FILE: src/dgsp_regs.sv
module dgsp_regs #(
   parameter int MAX_VERTICES = dgsp_pkg::DEF_MAX_VERTICES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [dgsp_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [dgsp_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [dgsp_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready,
   output logic [$clog2(MAX_VERTICES+1)-1:0]    vertex_total,
   output logic [$clog2(MAX_VERTICES)-1:0]      source_index,
   output logic                                 source_live
);
   import dgsp_pkg::*;

   localparam int CNT_W  = $clog2(MAX_VERTICES+1);
   localparam int VIDX_W = $clog2(MAX_VERTICES);

   logic [VERTEX_COUNT_W-1:0] vertex_count_ff, vertex_count_in;
   logic [VERTEX_INDEX_W-1:0] source_vertex_ff, source_vertex_in;
   logic [CSR_INDEX_W-1:0]    reg_index;
   logic                      write_strobe;

   assign pready       = 1'b1;
   assign reg_index    = paddr[CSR_ADDR_W-1:2];
   assign write_strobe = psel & penable & pwrite & pready;

   // Register writes.
   always_comb begin
      vertex_count_in  = vertex_count_ff;
      source_vertex_in = source_vertex_ff;
      if (write_strobe) begin
         case (reg_index)
            REG_VERTEX_COUNT:  vertex_count_in  = pwdata[VERTEX_COUNT_W-1:0];
            REG_SOURCE_VERTEX: source_vertex_in = pwdata[VERTEX_INDEX_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff  <= VERTEX_COUNT_RESET;
         source_vertex_ff <= SOURCE_VERTEX_RESET;
      end else begin
         vertex_count_ff  <= vertex_count_in;
         source_vertex_ff <= source_vertex_in;
      end
   end

   // Register reads.
   always_comb begin
      case (reg_index)
         REG_VERTEX_COUNT:  prdata = CSR_DATA_W'(vertex_count_ff);
         REG_SOURCE_VERTEX: prdata = CSR_DATA_W'(source_vertex_ff);
         default:           prdata = '0;
      endcase
   end

   // Clamp the vertex count into the supported range.
   always_comb begin
      if (int'(vertex_count_ff) < MIN_VERTICES) begin
         vertex_total = CNT_W'(MIN_VERTICES);
      end else if (int'(vertex_count_ff) > MAX_VERTICES) begin
         vertex_total = CNT_W'(MAX_VERTICES);
      end else begin
         vertex_total = CNT_W'(vertex_count_ff);
      end
   end

   // A source outside the graph leaves every vertex unreachable.
   assign source_live  = int'(source_vertex_ff) < int'(vertex_total);
   assign source_index = VIDX_W'(source_vertex_ff);

endmodule

FILE: src/dgsp_ctrl.sv
module dgsp_ctrl #(
   parameter int MAX_VERTICES = dgsp_pkg::DEF_MAX_VERTICES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_last,
   input  logic [$clog2(MAX_VERTICES+1)-1:0] vertex_total,
   input  dgsp_pkg::dp_status_type           status,
   output dgsp_pkg::dp_cmd_type              cmd,
   output logic [$clog2(MAX_VERTICES)-1:0]   scan_index,
   output logic                              scan_last,
   output logic                              req_ready
);
   import dgsp_pkg::*;

   localparam int CNT_W  = $clog2(MAX_VERTICES+1);
   localparam int VIDX_W = $clog2(MAX_VERTICES);

   localparam logic [3:0] S_IDLE        = 4'd0;
   localparam logic [3:0] S_INIT        = 4'd1;
   localparam logic [3:0] S_PICK        = 4'd2;
   localparam logic [3:0] S_PICK_DRAIN  = 4'd3;
   localparam logic [3:0] S_SETTLE      = 4'd4;
   localparam logic [3:0] S_RELAX       = 4'd5;
   localparam logic [3:0] S_RELAX_DRAIN = 4'd6;
   localparam logic [3:0] S_OUT_READ    = 4'd7;
   localparam logic [3:0] S_OUT_LOAD    = 4'd8;
   localparam logic [3:0] S_OUT_WAIT    = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [VIDX_W-1:0] index_ff, index_in;
   logic [CNT_W-1:0]  round_ff, round_in;
   logic              round_done;
   logic              round_last;

   assign scan_index = index_ff;
   assign scan_last  = CNT_W'(index_ff) == (vertex_total - CNT_W'(1));
   assign round_last = round_ff == (vertex_total - CNT_W'(2));
   assign req_ready  = state_ff == S_IDLE;

   // Sequencer: rounds of pick scan, settle, relax scan if pick known.
   always_comb begin
      state_in   = state_ff;
      index_in   = index_ff;
      round_in   = round_ff;
      round_done = 1'b0;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_last) begin
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            cmd.init = 1'b1;
            index_in = '0;
            round_in = '0;
            state_in = S_PICK;
         end
         S_PICK: begin
            cmd.pick_issue = 1'b1;
            if (scan_last) begin
               index_in = '0;
               state_in = S_PICK_DRAIN;
            end else begin
               index_in = index_ff + VIDX_W'(1);
            end
         end
         S_PICK_DRAIN: begin
            state_in = S_SETTLE;
         end
         S_SETTLE: begin
            cmd.settle = 1'b1;
            if (status.have_known) begin
               state_in = S_RELAX;
            end else begin
               round_done = 1'b1;
            end
         end
         S_RELAX: begin
            cmd.relax_issue = 1'b1;
            if (scan_last) begin
               index_in = '0;
               state_in = S_RELAX_DRAIN;
            end else begin
               index_in = index_ff + VIDX_W'(1);
            end
         end
         S_RELAX_DRAIN: begin
            round_done = 1'b1;
         end
         S_OUT_READ: begin
            state_in = S_OUT_LOAD;
         end
         S_OUT_LOAD: begin
            cmd.out_load = 1'b1;
            state_in     = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (status.rsp_taken) begin
               if (scan_last) begin
                  state_in = S_IDLE;
               end else begin
                  index_in = index_ff + VIDX_W'(1);
                  state_in = S_OUT_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // After the last round the results are read out in index order.
      if (round_done) begin
         index_in = '0;
         if (round_last) begin
            state_in = S_OUT_READ;
         end else begin
            round_in = round_ff + CNT_W'(1);
            state_in = S_PICK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         index_ff <= '0;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         index_ff <= index_in;
         round_ff <= round_in;
      end
   end

endmodule

FILE: src/dgsp_datapath.sv
module dgsp_datapath #(
   parameter int MAX_VERTICES  = dgsp_pkg::DEF_MAX_VERTICES,
   parameter int WEIGHT_BITS   = dgsp_pkg::DEF_WEIGHT_BITS,
   parameter int DISTANCE_BITS = dgsp_pkg::DEF_DISTANCE_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  dgsp_pkg::req_word_type          req_word,
   input  logic                            req_accept,
   input  dgsp_pkg::dp_cmd_type            cmd,
   input  logic [$clog2(MAX_VERTICES)-1:0] scan_index,
   input  logic                            scan_last,
   input  logic [$clog2(MAX_VERTICES)-1:0] source_index,
   input  logic                            source_live,
   output dgsp_pkg::dp_status_type         status,
   output dgsp_pkg::rsp_word_type          rsp_word,
   output logic                            rsp_valid,
   input  logic                            rsp_ready
);
   import dgsp_pkg::*;

   localparam int VIDX_W       = $clog2(MAX_VERTICES);
   localparam int MADDR_W      = 2 * VIDX_W;
   localparam int MATRIX_DEPTH = MAX_VERTICES << VIDX_W;
   localparam int SUM_W        = ((DISTANCE_BITS > WEIGHT_BITS) ?
                                  DISTANCE_BITS : WEIGHT_BITS) + 1;
   localparam logic [SUM_W-1:0] DIST_MAX = SUM_W'({DISTANCE_BITS{1'b1}});

   // Adjacency matrix and tentative distances.
   logic [WEIGHT_BITS-1:0]   matrix_mem [MATRIX_DEPTH];
   logic [DISTANCE_BITS-1:0] dist_mem   [MAX_VERTICES];

   logic [MADDR_W-1:0]       matrix_wr_addr;
   logic                     matrix_wr_ok;
   logic [WEIGHT_BITS-1:0]   weight_rd_ff;
   logic [DISTANCE_BITS-1:0] dist_rd_ff;
   logic                     dist_we;
   logic [VIDX_W-1:0]        dist_wa;
   logic [DISTANCE_BITS-1:0] dist_wd;

   // Scan state.
   logic [MAX_VERTICES-1:0]  known_ff, known_in;
   logic [MAX_VERTICES-1:0]  settled_ff, settled_in;
   logic                     pick_eval_ff, relax_eval_ff;
   logic [VIDX_W-1:0]        index_d_ff;
   logic                     have_known_ff, have_known_in;
   logic [VIDX_W-1:0]        best_ff, best_in;
   logic [DISTANCE_BITS-1:0] best_dist_ff, best_dist_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_word_type             rsp_word_ff, rsp_word_in;

   logic                     scan_first;
   logic                     have_cur;
   logic [VIDX_W-1:0]        best_cur;
   logic                     cand_known, cand_settled;
   logic                     pick_hit, pick_fill;
   logic [SUM_W-1:0]         sum_wide;
   logic [DISTANCE_BITS-1:0] sum_sat;
   logic                     relax_hit;

   // Matrix write from the input channel; out-of-range entries are dropped.
   assign matrix_wr_ok   = (int'(req_word.from_vertex) < MAX_VERTICES) &&
                           (int'(req_word.to_vertex) < MAX_VERTICES);
   assign matrix_wr_addr = {VIDX_W'(req_word.from_vertex), VIDX_W'(req_word.to_vertex)};

   always_ff @(posedge clock) begin
      if (req_accept && matrix_wr_ok) begin
         matrix_mem[matrix_wr_addr] <= WEIGHT_BITS'(req_word.edge_weight);
      end
      weight_rd_ff <= matrix_mem[{best_ff, scan_index}];
   end

   // Distance memory: one write port, one read port at the scan index.
   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[dist_wa] <= dist_wd;
      end
      dist_rd_ff <= dist_mem[scan_index];
   end

   // Candidate flags of the vertex whose distance was read last cycle.
   assign cand_known   = known_ff[index_d_ff];
   assign cand_settled = settled_ff[index_d_ff];

   // Pick step: least known distance, ties to the later index; with no
   // known vertex the highest unsettled index is taken.
   assign scan_first = index_d_ff == '0;
   assign have_cur   = have_known_ff & ~scan_first;
   assign best_cur   = scan_first ? '0 : best_ff;
   assign pick_hit   = !cand_settled && cand_known &&
                       (!have_cur || (dist_rd_ff <= best_dist_ff));
   assign pick_fill  = !cand_settled && !cand_known && !have_cur;

   always_comb begin
      have_known_in = have_known_ff;
      best_in       = best_ff;
      best_dist_in  = best_dist_ff;
      if (pick_eval_ff) begin
         have_known_in = have_cur;
         best_in       = best_cur;
         if (pick_hit) begin
            have_known_in = 1'b1;
            best_in       = index_d_ff;
            best_dist_in  = dist_rd_ff;
         end else if (pick_fill) begin
            best_in = index_d_ff;
         end
      end
   end

   // Relax step: saturating sum through the settled vertex.
   assign sum_wide  = SUM_W'(best_dist_ff) + SUM_W'(weight_rd_ff);
   assign sum_sat   = (sum_wide > DIST_MAX) ? {DISTANCE_BITS{1'b1}} :
                                              DISTANCE_BITS'(sum_wide);
   assign relax_hit = relax_eval_ff && !cand_settled && (weight_rd_ff != '0) &&
                      (!cand_known || (sum_sat < dist_rd_ff));

   // Distance write: source at start, improved distances while relaxing.
   always_comb begin
      if (cmd.init) begin
         dist_we = source_live;
         dist_wa = source_index;
         dist_wd = '0;
      end else begin
         dist_we = relax_hit;
         dist_wa = index_d_ff;
         dist_wd = sum_sat;
      end
   end

   // Per-vertex known and settled flags.
   always_comb begin
      known_in   = known_ff;
      settled_in = settled_ff;
      if (cmd.init) begin
         known_in   = '0;
         settled_in = '0;
         if (source_live) begin
            known_in[source_index] = 1'b1;
         end
      end
      if (cmd.settle) begin
         settled_in[best_ff] = 1'b1;
      end
      if (relax_hit) begin
         known_in[index_d_ff] = 1'b1;
      end
   end

   // Result register; it holds until the word is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (cmd.out_load) begin
         rsp_valid_in             = 1'b1;
         rsp_word_in.vertex_index = VERTEX_INDEX_W'(scan_index);
         rsp_word_in.reachable    = known_ff[scan_index];
         rsp_word_in.path_length  = known_ff[scan_index] ?
                                    PATH_LENGTH_W'(dist_rd_ff) : '0;
         rsp_word_in.last_vertex  = scan_last;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff      <= '0;
         settled_ff    <= '0;
         pick_eval_ff  <= 1'b0;
         relax_eval_ff <= 1'b0;
         have_known_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         known_ff      <= known_in;
         settled_ff    <= settled_in;
         pick_eval_ff  <= cmd.pick_issue;
         relax_eval_ff <= cmd.relax_issue;
         have_known_ff <= have_known_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      index_d_ff   <= scan_index;
      best_ff      <= best_in;
      best_dist_ff <= best_dist_in;
      rsp_word_ff  <= rsp_word_in;
   end

   assign status.have_known = have_known_ff;
   assign status.rsp_taken  = rsp_valid_ff & rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_word          = rsp_word_ff;

endmodule

FILE: src/dense_graph_shortest_paths_core.sv
// Channel   Handshake             Word           Direction
// req       req_valid/req_ready   req_word       in: one matrix weight
// rsp       rsp_valid/rsp_ready   rsp_word       out: one vertex result
// csr       psel/penable/pready   pwdata/prdata  register access
//
// Weights load at one word per cycle while the core is idle.
// After the word marked last, the core runs n-1 rounds: a pick scan, a settle step
// and, while a known vertex is left, a relax scan through the distance memory.
// Results then leave one vertex at a time in index order, each after the last is taken.
// Reset is synchronous; req_ready is low from the last word until the final result
// is taken, and a stalled result holds the core in place.
module dense_graph_shortest_paths_core #(
   parameter int MAX_VERTICES  = dgsp_pkg::DEF_MAX_VERTICES,
   parameter int WEIGHT_BITS   = dgsp_pkg::DEF_WEIGHT_BITS,
   parameter int DISTANCE_BITS = dgsp_pkg::DEF_DISTANCE_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  dgsp_pkg::req_word_type          req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output dgsp_pkg::rsp_word_type          rsp_word,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [dgsp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [dgsp_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [dgsp_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import dgsp_pkg::*;

   localparam int CNT_W  = $clog2(MAX_VERTICES+1);
   localparam int VIDX_W = $clog2(MAX_VERTICES);

   logic [CNT_W-1:0]  vertex_total;
   logic [VIDX_W-1:0] source_index;
   logic              source_live;
   logic [VIDX_W-1:0] scan_index;
   logic              scan_last;
   logic              req_accept;
   dp_cmd_type        cmd;
   dp_status_type     status;

   assign req_accept = req_valid & req_ready;

   // Configuration registers.
   dgsp_regs #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_regs (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .vertex_total (vertex_total),
      .source_index (source_index),
      .source_live  (source_live)
   );

   // Round sequencer.
   dgsp_ctrl #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_last     (req_word.last_weight),
      .vertex_total (vertex_total),
      .status       (status),
      .cmd          (cmd),
      .scan_index   (scan_index),
      .scan_last    (scan_last),
      .req_ready    (req_ready)
   );

   // Matrix, distances and result register.
   dgsp_datapath #(
      .MAX_VERTICES  (MAX_VERTICES),
      .WEIGHT_BITS   (WEIGHT_BITS),
      .DISTANCE_BITS (DISTANCE_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_word     (req_word),
      .req_accept   (req_accept),
      .cmd          (cmd),
      .scan_index   (scan_index),
      .scan_last    (scan_last),
      .source_index (source_index),
      .source_live  (source_live),
      .status       (status),
      .rsp_word     (rsp_word),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready)
   );

endmodule

FILE: src/dgsp_checker.sv
module dgsp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input dgsp_pkg::req_word_type          req_word,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input dgsp_pkg::rsp_word_type          rsp_word,
   input logic                            psel,
   input logic                            penable,
   input logic                            pwrite,
   input logic [dgsp_pkg::CSR_ADDR_W-1:0] paddr,
   input logic [dgsp_pkg::CSR_DATA_W-1:0] pwdata,
   input logic [dgsp_pkg::CSR_DATA_W-1:0] prdata,
   input logic                            pready
);
   import dgsp_pkg::*;

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // The core never loads weights while a result is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while a result is pending");

   // The last weight starts the run and closes the input.
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_word.last_weight |=> !req_ready)
      else $error("input still open after the last weight");

   // Taking the final result reopens the input.
   a_final_reopens: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_word.last_vertex |=> req_ready && !rsp_valid)
      else $error("input not reopened after the final result");

   // Reset leaves the core idle and ready once it is released.
   a_reset_idle: assert property (@(posedge clock)
      $fell(reset) |-> req_ready && !rsp_valid && pready)
      else $error("core not idle after reset");

endmodule

bind dense_graph_shortest_paths_core dgsp_checker u_dgsp_checker (.*);

FILE: tb/sv/dense_graph_shortest_paths_checker.sv
`timescale 1ns / 100ps
module dense_graph_shortest_paths_checker
   import dgsp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_word_type          req_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_word_type          rsp_word,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic                  pready,
   output int                    error_count,
   output int                    pending_count,
   output int                    results_checked
);

   localparam int MAX_V = DEF_MAX_VERTICES;
   localparam logic [PATH_LENGTH_W:0] LENGTH_CAP = {1'b0, {PATH_LENGTH_W{1'b1}}};

   // Shadow copy of the adjacency matrix and of the search state.
   logic [EDGE_WEIGHT_W-1:0]  edge_cost [MAX_V][MAX_V];
   logic [PATH_LENGTH_W-1:0]  best_len [MAX_V];
   bit                        known [MAX_V];
   bit                        finished [MAX_V];

   // Shadow copy of the registers, taken from the writes seen on the port.
   logic [VERTEX_COUNT_W-1:0] vertex_count_cfg;
   logic [VERTEX_INDEX_W-1:0] source_cfg;

   rsp_word_type expected_paths [$];
   int fail_tally = 0;
   int checked_tally = 0;

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH result %0d: %s", $realtime, checked_tally, msg);
      fail_tally++;
   endtask

   // Run the rounds of the search and queue one distance word per vertex in use.
   task automatic predict_distances();
      int n;
      int u;
      int v;
      bit have;
      logic [PATH_LENGTH_W-1:0] best_d;
      logic [PATH_LENGTH_W:0] sum;
      rsp_word_type word;
      n = int'(vertex_count_cfg);
      if (n < MIN_VERTICES) n = MIN_VERTICES;
      if (n > MAX_V) n = MAX_V;
      for (v = 0; v < MAX_V; v++) begin
         best_len[v] = '0;
         known[v] = 1'b0;
         finished[v] = 1'b0;
      end
      if (source_cfg < n) known[source_cfg] = 1'b1;
      for (int r = 0; r + 1 < n; r++) begin
         // Least known distance wins, ties to the higher index; with nothing
         // known the highest unsettled vertex is taken.
         u = 0;
         have = 1'b0;
         best_d = '0;
         for (v = 0; v < n; v++) begin
            if (finished[v]) continue;
            if (known[v]) begin
               if (!have || best_len[v] <= best_d) begin
                  have = 1'b1;
                  best_d = best_len[v];
                  u = v;
               end
            end else if (!have) begin
               u = v;
            end
         end
         finished[u] = 1'b1;
         if (!known[u]) continue;
         // Relax the edges leaving the settled vertex, clamping long sums.
         for (v = 0; v < n; v++) begin
            if (finished[v] || edge_cost[u][v] == '0) continue;
            sum = best_len[u] + edge_cost[u][v];
            if (sum > LENGTH_CAP) sum = LENGTH_CAP;
            if (!known[v] || sum < best_len[v]) begin
               best_len[v] = sum[PATH_LENGTH_W-1:0];
               known[v] = 1'b1;
            end
         end
      end
      for (v = 0; v < n; v++) begin
         word.vertex_index = VERTEX_INDEX_W'(v);
         word.path_length  = known[v] ? best_len[v] : '0;
         word.reachable    = known[v];
         word.last_vertex  = (v + 1 == n);
         expected_paths.push_back(word);
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         vertex_count_cfg = VERTEX_COUNT_RESET;
         source_cfg = SOURCE_VERTEX_RESET;
         expected_paths.delete();
         for (int r = 0; r < MAX_V; r++) begin
            for (int c = 0; c < MAX_V; c++) edge_cost[r][c] = '0;
         end
      end else begin
         // Register writes complete on the access cycle.
         if (psel && penable && pwrite && pready) begin
            if (paddr[CSR_ADDR_W-1:2] == REG_VERTEX_COUNT) begin
               vertex_count_cfg = pwdata[VERTEX_COUNT_W-1:0];
            end else if (paddr[CSR_ADDR_W-1:2] == REG_SOURCE_VERTEX) begin
               source_cfg = pwdata[VERTEX_INDEX_W-1:0];
            end
         end
         // Compare each accepted result word with the oldest prediction.
         if (rsp_valid && rsp_ready) begin
            checked_tally++;
            if (expected_paths.size() == 0) begin
               report_mismatch($sformatf("unexpected word for vertex %0d",
                                         rsp_word.vertex_index));
            end else begin
               want = expected_paths.pop_front();
               if (rsp_word.vertex_index !== want.vertex_index)
                  report_mismatch($sformatf("vertex_index got %0d expected %0d",
                                            rsp_word.vertex_index, want.vertex_index));
               if (rsp_word.path_length !== want.path_length)
                  report_mismatch($sformatf("vertex %0d path_length got %0d expected %0d",
                                            want.vertex_index, rsp_word.path_length,
                                            want.path_length));
               if (rsp_word.reachable !== want.reachable)
                  report_mismatch($sformatf("vertex %0d reachable got %0b expected %0b",
                                            want.vertex_index, rsp_word.reachable,
                                            want.reachable));
               if (rsp_word.last_vertex !== want.last_vertex)
                  report_mismatch($sformatf("vertex %0d last_vertex got %0b expected %0b",
                                            want.vertex_index, rsp_word.last_vertex,
                                            want.last_vertex));
            end
         end
         // Each accepted word stores a weight; the marked one starts a search.
         if (req_valid && req_ready) begin
            edge_cost[req_word.from_vertex][req_word.to_vertex] = req_word.edge_weight;
            if (req_word.last_weight) predict_distances();
         end
      end
      error_count <= fail_tally;
      pending_count <= expected_paths.size();
      results_checked <= checked_tally;
   end

endmodule

FILE: tb/sv/dense_graph_shortest_paths_core_test.sv
`timescale 1ns / 100ps
module dense_graph_shortest_paths_core_test;
   import dgsp_pkg::*;

   localparam int ITEM_GOAL    = 300;
   localparam int RESULT_GOAL  = 48;
   localparam int STALL_LIMIT  = 4000;
   localparam int LONG_HOLD    = 300;
   localparam int SETTLE_WAIT  = 8;
   localparam int DRAIN_WAIT   = 40;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid;
   logic                  req_ready;
   req_word_type          req_word;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_word_type          rsp_word;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    error_count;
   int                    pending_count;
   int                    results_checked;

   // Loader bookkeeping: which matrix cells hold a weight, and how busy we are.
   bit filled [DEF_MAX_VERTICES][DEF_MAX_VERTICES];
   int items_sent = 0;
   int runs = 0;
   int burst_left;
   int count_cfg = int'(VERTEX_COUNT_RESET);
   int n_low = DEF_MAX_VERTICES;
   int n_high = 0;
   bit hold_armed = 1'b0;
   bit hold_done = 1'b0;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   dense_graph_shortest_paths_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   dense_graph_shortest_paths_checker path_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_word        (req_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_word        (rsp_word),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .pready          (pready),
      .error_count     (error_count),
      .pending_count   (pending_count),
      .results_checked (results_checked)
   );

   function automatic int active_vertices(input int count);
      if (count < MIN_VERTICES) return MIN_VERTICES;
      if (count > DEF_MAX_VERTICES) return DEF_MAX_VERTICES;
      return count;
   endfunction

   // Mix of no edge, small weights that make ties, mid weights, the top of the range and fully random weights.
   function automatic logic [EDGE_WEIGHT_W-1:0] pick_weight();
      case ($urandom_range(0, 9))
         0, 1, 2: return '0;
         3, 4, 5: return EDGE_WEIGHT_W'($urandom_range(1, 4));
         6, 7:    return EDGE_WEIGHT_W'($urandom_range(1, 1000));
         8:       return 16'hFFFF - EDGE_WEIGHT_W'($urandom_range(0, 3));
         default: return EDGE_WEIGHT_W'($urandom());
      endcase
   endfunction

   function automatic req_word_type build_word(input int row, input int col,
                                               input logic [EDGE_WEIGHT_W-1:0] weight,
                                               input bit last);
      req_word_type w;
      w.from_vertex = VERTEX_INDEX_W'(row);
      w.to_vertex   = VERTEX_INDEX_W'(col);
      w.edge_weight = weight;
      w.last_weight = last;
      return w;
   endfunction

   // Offer one word from a falling edge and return on a falling edge once it is taken.
   task automatic send_word(input req_word_type w);
      int gap;
      req_word = w;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
      filled[w.from_vertex][w.to_vertex] = 1'b1;
      // At the end of a burst drop valid for a while, or sometimes not at all.
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 32);
      end
   endtask

   // Register write once the core is idle: setup cycle, then access cycle.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int value);
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      if (idx == REG_VERTEX_COUNT) count_cfg = value;
   endtask

   // Fill any unwritten cell of the active square, add some rewrites, then start.
   task automatic load_graph(input int n, input int extra);
      int row;
      for (int r = 0; r < n; r++) begin
         for (int c = 0; c < n; c++) begin
            if (!filled[r][c]) send_word(build_word(r, c, pick_weight(), 1'b0));
         end
      end
      repeat (extra) begin
         row = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
         send_word(build_word(row, $urandom_range(0, 15), pick_weight(), 1'b0));
      end
      send_word(build_word($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                           pick_weight(), 1'b1));
      runs++;
      if (n < n_low) n_low = n;
      if (n > n_high) n_high = n;
   endtask

   // Result side: random stall patterns that change from stretch to stretch, plus one
   // long hold-off while the loader keeps offering the next graph.
   initial begin
      int mode;
      int stretch;
      stretch = 0;
      mode = 0;
      rsp_ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_armed && rsp_valid) begin
            hold_armed = 1'b0;
            rsp_ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_done = 1'b1;
         end
         if (stretch == 0) begin
            mode = $urandom_range(0, 2);
            stretch = $urandom_range(8, 64);
         end
         stretch--;
         case (mode)
            0:       rsp_ready = 1'b1;
            1:       rsp_ready = 1'($urandom_range(0, 1));
            default: rsp_ready = ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Watchdog: too long without any word moving on any port ends the run.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
            quiet = 0;
         else
            quiet++;
      end
      $display("[%0t] timeout: no word moved for %0d cycles", $realtime, STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int phase;
      int n;
      bit reconfig;
      req_valid = 1'b0;
      req_word = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      burst_left = $urandom_range(1, 32);
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Two vertices, one maximum-weight edge.
      write_reg(REG_VERTEX_COUNT, 2);
      write_reg(REG_SOURCE_VERTEX, 0);
      send_word(build_word(0, 0, 16'h0000, 1'b0));
      send_word(build_word(0, 1, 16'hFFFF, 1'b0));
      send_word(build_word(1, 0, 16'h0000, 1'b0));
      send_word(build_word(1, 1, 16'h0000, 1'b1));
      // A count below the minimum acts as two; measure from vertex one.
      write_reg(REG_VERTEX_COUNT, 0);
      write_reg(REG_SOURCE_VERTEX, 1);
      send_word(build_word(1, 0, 16'd5, 1'b1));
      // Source beyond the vertex count: nothing is reachable.
      write_reg(REG_VERTEX_COUNT, 1);
      write_reg(REG_SOURCE_VERTEX, 3);
      send_word(build_word(0, 1, 16'd7, 1'b1));
      // Four vertices: equal distances tie, and vertex three has no way in.
      write_reg(REG_VERTEX_COUNT, 4);
      write_reg(REG_SOURCE_VERTEX, 0);
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            send_word(build_word(r, c, (r < c && c != 3) ? 16'd2 : 16'd0,
                                 (r == 3 && c == 3)));
         end
      end
      runs = 4;
      n_low = 2;
      n_high = 4;

      // Random graphs, mostly small; the full size and the top register value
      // are forced once each, and one run is followed straight by the next
      // graph while the result side holds off.
      phase = 0;
      while (items_sent < ITEM_GOAL || results_checked < RESULT_GOAL) begin
         reconfig = (phase == 3 || phase == 6) || (phase != 5 && $urandom_range(0, 2) == 0);
         if (reconfig) begin
            if (phase == 3) n = DEF_MAX_VERTICES;
            else if (phase == 6) n = 31;
            else begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5, 6: n = $urandom_range(2, 6);
                  7:                   n = $urandom_range(7, 10);
                  8:                   n = $urandom_range(0, 1);
                  default:             n = $urandom_range(11, 31);
               endcase
            end
            write_reg(REG_VERTEX_COUNT, n);
            if (phase == 3)
               write_reg(REG_SOURCE_VERTEX, 15);
            else if ($urandom_range(0, 3) != 0)
               write_reg(REG_SOURCE_VERTEX, $urandom_range(0, active_vertices(n) - 1));
            else
               write_reg(REG_SOURCE_VERTEX, $urandom_range(0, 15));
         end
         if (phase == 4) hold_armed = 1'b1;
         load_graph(active_vertices(count_cfg), $urandom_range(0, 12));
         phase++;
      end

      // Let every predicted word arrive, then watch a little longer for strays.
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      $display("Loaded %0d matrix words into %0d searches and checked %0d vertex results.",
               items_sent, runs, results_checked);
      $display("Active sizes %0d to %0d, counts outside the range, far sources; long stall %s.",
               n_low, n_high, hold_done ? "done" : "missed");
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
